@@ design/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants for the response frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    // Frame constants
    localparam logic [7:0]  HDR_BYTE      = 8'hFB;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // Input opcodes (code 3 is unused and ignored)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_ID      = 3'd2,
        PH_CODE    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TIMEOUT    = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_WRONG_ID   = 3'd3,
        ST_WRONG_CODE = 3'd4,
        ST_BAD_SUM    = 3'd5
    } status_t;

    // One input beat after unpacking
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [7:0] expected_id;
        logic [7:0] expected_code;
        logic [7:0] expected_len;
    } item_t;

    // One result beat
    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic       last;
    } result_t;

endpackage

@@ design/rfc_in_stage.sv @@
// ----------------------------------------------------------------------------
// rfc_in_stage
// Input register: captures one beat from the slave side and holds it
// until the checker core takes it.
// ----------------------------------------------------------------------------
module rfc_in_stage
    import rfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rx_byte, expected_id, expected_code, expected_len
    input  logic [1:0]  s_tuser,   // op
    input  logic        take,
    output logic        item_valid,
    output item_t       item
);

    logic  valid_reg;
    item_t item_reg;

    // Free when empty or when the held beat leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op            <= s_tuser;
            item_reg.rx_byte       <= s_tdata[7:0];
            item_reg.expected_id   <= s_tdata[15:8];
            item_reg.expected_code <= s_tdata[23:16];
            item_reg.expected_len  <= s_tdata[31:24];
        end
    end

endmodule

@@ design/rfc_core.sv @@
// ----------------------------------------------------------------------------
// rfc_core
// Frame state machine: header, id, code, payload and checksum matching,
// tick timeout, and result generation, one beat per cycle unless a result waits on the output side.
// ----------------------------------------------------------------------------
module rfc_core
    import rfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        item_valid,
    input  item_t       item,
    input  logic        out_ready,
    output logic        take,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg,   phase_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [7:0]  left_reg,    left_next;
    logic [15:0] tick_reg,    tick_next;
    logic [7:0]  want_id_reg, want_id_next;
    logic [7:0]  want_code_reg, want_code_next;
    logic [7:0]  want_len_reg,  want_len_next;
    logic [15:0] timeout_reg;
    logic        has_result;

    // A beat with no result never waits on the output side
    assign take      = item_valid && (out_ready || !has_result);
    assign res_valid = item_valid && has_result;

    // Timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Next state
    always_comb begin
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        left_next      = left_reg;
        tick_next      = tick_reg;
        want_id_next   = want_id_reg;
        want_code_next = want_code_reg;
        want_len_next  = want_len_reg;
        if (item.op == OP_START) begin
            want_id_next   = item.expected_id;
            want_code_next = item.expected_code;
            want_len_next  = item.expected_len;
            sum_next       = 8'd0;
            left_next      = item.expected_len;
            tick_next      = 16'd0;
            phase_next     = PH_HEADER;
        end else if (item.op == OP_BYTE) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (item.rx_byte != HDR_BYTE) begin
                        phase_next = PH_IDLE;
                    end else begin
                        sum_next   = HDR_BYTE;
                        phase_next = PH_ID;
                    end
                end
                PH_ID: begin
                    if (item.rx_byte != want_id_reg) begin
                        phase_next = PH_IDLE;
                    end else begin
                        sum_next   = sum_reg + item.rx_byte;
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (item.rx_byte != want_code_reg) begin
                        phase_next = PH_IDLE;
                    end else begin
                        sum_next   = sum_reg + item.rx_byte;
                        left_next  = want_len_reg;
                        phase_next = (want_len_reg == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    sum_next  = sum_reg + item.rx_byte;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end else if (item.op == OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                if (tick_reg >= timeout_reg) begin
                    phase_next = PH_IDLE;
                end else begin
                    tick_next = tick_reg + 16'd1;
                end
            end
        end
    end

    // Result outputs
    always_comb begin
        has_result       = 1'b0;
        res.kind         = KIND_STATUS;
        res.payload_byte = 8'd0;
        res.status       = ST_OK;
        res.last         = 1'b1;
        if (item.op == OP_BYTE) begin
            case (phase_reg)
                PH_HEADER: begin
                    if (item.rx_byte != HDR_BYTE) begin
                        has_result = 1'b1;
                        res.status = ST_BAD_HEADER;
                    end
                end
                PH_ID: begin
                    if (item.rx_byte != want_id_reg) begin
                        has_result = 1'b1;
                        res.status = ST_WRONG_ID;
                    end
                end
                PH_CODE: begin
                    if (item.rx_byte != want_code_reg) begin
                        has_result = 1'b1;
                        res.status = ST_WRONG_CODE;
                    end
                end
                PH_PAYLOAD: begin
                    has_result       = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = item.rx_byte;
                    res.last         = 1'b0;
                end
                PH_CHECK: begin
                    has_result = 1'b1;
                    res.status = (item.rx_byte == sum_reg) ? ST_OK : ST_BAD_SUM;
                end
                default: begin
                    has_result = 1'b0;
                end
            endcase
        end else if (item.op == OP_TICK) begin
            if (phase_reg != PH_IDLE && tick_reg >= timeout_reg) begin
                has_result = 1'b1;
                res.status = ST_TIMEOUT;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            sum_reg       <= 8'd0;
            left_reg      <= 8'd0;
            tick_reg      <= 16'd0;
            want_id_reg   <= 8'd0;
            want_code_reg <= 8'd0;
            want_len_reg  <= 8'd0;
        end else if (take) begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            tick_reg      <= tick_next;
            want_id_reg   <= want_id_next;
            want_code_reg <= want_code_next;
            want_len_reg  <= want_len_next;
        end
    end

endmodule

@@ design/rfc_out_stage.sv @@
// ----------------------------------------------------------------------------
// rfc_out_stage
// Result register: holds one result beat for the master side.
// ----------------------------------------------------------------------------
module rfc_out_stage
    import rfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        res_valid,
    input  result_t     res,
    output logic        out_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // payload_byte, status, zero fill
    output logic        m_tuser,   // kind
    output logic        m_tlast
);

    logic    valid_reg;
    result_t res_reg;

    // Room when empty or when the held beat is taken this cycle
    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {5'd0, res_reg.status, res_reg.payload_byte};
    assign m_tuser   = res_reg.kind;
    assign m_tlast   = res_reg.last;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg <= res_valid;
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (out_ready && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

@@ design/response_frame_checker.sv @@
// Timing: a result passes through the input register, then the result register, on
// its way to the master side; a beat with a result waits while the result
// register is full and not taken.
// Throughput: one beat per cycle while no result waits on a full result register.
// Reset: synchronous on aresetn low; checker goes idle, timeout returns to 500.
// ----------------------------------------------------------------------------
// response_frame_checker
// Checks a reply frame byte by byte and reports payload bytes and status.
// ----------------------------------------------------------------------------
module response_frame_checker
    import rfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // timeout_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // rx_byte, expected_id, expected_code, expected_len
    input  logic [1:0]  s_tuser,       // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // payload_byte, status, zero fill
    output logic        m_tuser,       // kind
    output logic        m_tlast
);

    logic    take;
    logic    item_valid;
    item_t   item;
    logic    out_ready;
    logic    res_valid;
    result_t res;

    // Input register
    rfc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Frame checker
    rfc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .out_ready   (out_ready),
        .take        (take),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result register
    rfc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ verif/response_frame_checker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_frame_checker_test
// Self-checking bench for the reply frame checker. A short table of directed
// beats runs first. Random replies follow, mostly well formed with random ids,
// codes, payloads and ticks, some corrupted, cut short or mixed with noise.
// The bench predicts every result and compares it with the master side. Both
// sides idle at random, and the timeout is changed between phases.
// ----------------------------------------------------------------------------
module response_frame_checker_test;
    import rfc_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_BEATS = 75;
    localparam int         SETTLE      = 8;

    typedef enum logic [1:0] {
        ROW_PRED,   // result comes from the frame predictor
        ROW_NONE,   // no result is possible
        ROW_RES     // result typed into the table
    } row_mode_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [7:0] id;
        logic [7:0] code;
        logic [7:0] len;
        row_mode_t  mode;
        result_t    res;
    } row_t;

    localparam result_t NO_RES = '0;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = 32'd0;   // rx_byte, expected_id, expected_code, expected_len
    logic [1:0]  s_tuser     = 2'd0;    // op
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;               // payload_byte, status, zero fill
    logic        m_tuser;               // kind
    logic        m_tlast;

    response_frame_checker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state, at reset values
    phase_t      frm_phase  = PH_IDLE;
    logic [7:0]  frm_sum    = 8'd0;
    logic [7:0]  frm_left   = 8'd0;
    logic [15:0] frm_ticks  = 16'd0;
    logic [7:0]  frm_id     = 8'd0;
    logic [7:0]  frm_code   = 8'd0;
    logic [7:0]  frm_len    = 8'd0;
    logic [15:0] frm_tmo    = TIMEOUT_RESET;

    result_t     reply_q[$];     // results still owed by the block
    item_t       plan_q[$];      // beats of the reply being sent
    row_t        dir_q[$];

    int          errors      = 0;
    int          n_beats     = 0;
    int          n_live      = 0;
    int          n_payload   = 0;
    int          n_status    = 0;
    int          n_timeout   = 0;
    int          n_settings  = 0;
    int          calm_s      = 0;
    int          calm_m      = 0;
    int          stall_m     = 0;
    int          cycles      = 0;
    result_t     got;

    // Queue tails
    function automatic void add_reply(input result_t r);
        reply_q.insert(reply_q.size(), r);
    endfunction

    function automatic void add_plan(input item_t it);
        plan_q.insert(plan_q.size(), it);
    endfunction

    function automatic void add_row(input row_t row);
        dir_q.insert(dir_q.size(), row);
    endfunction

    // Advance the frame predictor by one accepted beat
    task automatic frame_step(input item_t it, output bit hit, output result_t r);
        bit      done;
        status_t st;
        begin
            hit  = 1'b0;
            done = 1'b0;
            st   = ST_OK;
            r    = NO_RES;
            if (it.op == OP_START) begin
                frm_id    = it.expected_id;
                frm_code  = it.expected_code;
                frm_len   = it.expected_len;
                frm_sum   = 8'd0;
                frm_left  = it.expected_len;
                frm_ticks = 16'd0;
                frm_phase = PH_HEADER;
            end else if (frm_phase != PH_IDLE && it.op == OP_BYTE) begin
                case (frm_phase)
                    PH_HEADER: begin
                        if (it.rx_byte != HDR_BYTE) begin
                            done = 1'b1;
                            st   = ST_BAD_HEADER;
                        end else begin
                            frm_sum   = HDR_BYTE;
                            frm_phase = PH_ID;
                        end
                    end
                    PH_ID: begin
                        if (it.rx_byte != frm_id) begin
                            done = 1'b1;
                            st   = ST_WRONG_ID;
                        end else begin
                            frm_sum   = frm_sum + it.rx_byte;
                            frm_phase = PH_CODE;
                        end
                    end
                    PH_CODE: begin
                        if (it.rx_byte != frm_code) begin
                            done = 1'b1;
                            st   = ST_WRONG_CODE;
                        end else begin
                            frm_sum   = frm_sum + it.rx_byte;
                            frm_left  = frm_len;
                            frm_phase = (frm_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        frm_sum  = frm_sum + it.rx_byte;
                        frm_left = frm_left - 8'd1;
                        if (frm_left == 8'd0) frm_phase = PH_CHECK;
                        hit            = 1'b1;
                        r.kind         = KIND_PAYLOAD;
                        r.payload_byte = it.rx_byte;
                    end
                    PH_CHECK: begin
                        done = 1'b1;
                        st   = (it.rx_byte == frm_sum) ? ST_OK : ST_BAD_SUM;
                    end
                    default: frm_phase = PH_IDLE;
                endcase
            end else if (frm_phase != PH_IDLE && it.op == OP_TICK) begin
                if (frm_ticks >= frm_tmo) begin
                    done = 1'b1;
                    st   = ST_TIMEOUT;
                end else begin
                    frm_ticks = frm_ticks + 16'd1;
                end
            end
            // a status ends the reply
            if (done) begin
                hit       = 1'b1;
                r.kind    = KIND_STATUS;
                r.status  = st;
                r.last    = 1'b1;
                frm_phase = PH_IDLE;
            end
        end
    endtask

    function automatic item_t rnd_item(input logic [1:0] op);
        item_t it;
        begin
            it.op            = op;
            it.rx_byte       = 8'($urandom);
            it.expected_id   = 8'($urandom);
            it.expected_code = 8'($urandom);
            it.expected_len  = 8'($urandom);
            return it;
        end
    endfunction

    function automatic row_t mk_row(input logic [1:0] op, input logic [7:0] rx_byte,
                                    input logic [7:0] id, input logic [7:0] code,
                                    input logic [7:0] len, input row_mode_t mode,
                                    input result_t res);
        row_t row;
        begin
            row.op      = op;
            row.rx_byte = rx_byte;
            row.id      = id;
            row.code    = code;
            row.len     = len;
            row.mode    = mode;
            row.res     = res;
            return row;
        end
    endfunction

    // Send one beat after a random gap, then book its expected result
    task automatic drive_beat(input item_t it, input row_mode_t mode, input result_t res);
        int      gap;
        bit      hit;
        bit      live;
        result_t r;
        begin
            if (calm_s > 0) begin
                calm_s = calm_s - 1;
                gap    = 0;
            end else begin
                gap = $urandom_range(0, 7);
                if ($urandom_range(0, 30) == 0) calm_s = $urandom_range(10, 40);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= it.op;
            s_tdata  <= {it.expected_len, it.expected_code, it.expected_id, it.rx_byte};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            // beat taken at this edge
            live = (it.op == OP_START) ||
                   (frm_phase != PH_IDLE && (it.op == OP_BYTE || it.op == OP_TICK));
            frame_step(it, hit, r);
            case (mode)
                ROW_PRED: if (hit) add_reply(r);
                ROW_RES:  add_reply(res);
                default:  ;
            endcase
            n_beats = n_beats + 1;
            if (live) n_live = n_live + 1;
        end
    endtask

    // Hold the sender until every owed result is in, then let the pipe settle
    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            while (reply_q.size() != 0) @(posedge aclk);
            repeat (SETTLE) @(posedge aclk);
        end
    endtask

    task automatic write_timeout(input logic [15:0] value);
        begin
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= value;
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            frm_tmo    = value;
            n_settings = n_settings + 1;
        end
    endtask

    // Plan one reply: start, header, id, code, payload, checksum, with ticks,
    // occasional corruption, truncation and noise around it
    task automatic plan_reply();
        item_t      it;
        logic [7:0] fr[$];
        logic [7:0] id;
        logic [7:0] code;
        logic [7:0] sum;
        logic [7:0] b;
        int         len;
        int         cut;
        begin
            id   = 8'($urandom);
            code = 8'($urandom);
            len  = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    add_plan(rnd_item(2'($urandom_range(0, 3))));
            fr.insert(fr.size(), HDR_BYTE);
            fr.insert(fr.size(), id);
            fr.insert(fr.size(), code);
            sum = HDR_BYTE + id + code;
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom);
                fr.insert(fr.size(), b);
                sum = sum + b;
            end
            fr.insert(fr.size(), sum);
            if ($urandom_range(0, 5) == 0)
                fr[$urandom_range(0, fr.size() - 1)] = 8'($urandom);
            cut = fr.size();
            if ($urandom_range(0, 7) == 0) cut = $urandom_range(0, fr.size() - 1);

            it               = rnd_item(OP_START);
            it.expected_id   = id;
            it.expected_code = code;
            it.expected_len  = 8'(len);
            add_plan(it);
            for (int i = 0; i < cut; i++) begin
                if ($urandom_range(0, 5) == 0) add_plan(rnd_item(OP_TICK));
                it         = rnd_item(OP_BYTE);
                it.rx_byte = fr[i];
                add_plan(it);
            end
            // a cut reply waits on ticks
            if (cut < fr.size())
                repeat ($urandom_range(1, 8)) add_plan(rnd_item(OP_TICK));
            if ($urandom_range(0, 7) == 0) add_plan(rnd_item(OP_BYTE));
        end
    endtask

    // Result side: random stalls, compare each beat with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected result beat: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    errors = errors + 1;
                end else begin
                    got = reply_q.pop_front();
                    if (m_tuser !== got.kind) begin
                        $error("kind: expected %0d, actual %0d", got.kind, m_tuser);
                        errors = errors + 1;
                    end
                    if (m_tdata[7:0] !== got.payload_byte) begin
                        $error("payload_byte: expected %h, actual %h",
                               got.payload_byte, m_tdata[7:0]);
                        errors = errors + 1;
                    end
                    if (m_tdata[10:8] !== got.status) begin
                        $error("status: expected %0d, actual %0d", got.status, m_tdata[10:8]);
                        errors = errors + 1;
                    end
                    if (m_tlast !== got.last) begin
                        $error("last: expected %0d, actual %0d", got.last, m_tlast);
                        errors = errors + 1;
                    end
                    if (got.kind == KIND_PAYLOAD) n_payload = n_payload + 1;
                    else n_status = n_status + 1;
                    if (got.kind == KIND_STATUS && got.status == ST_TIMEOUT)
                        n_timeout = n_timeout + 1;
                end
                if (calm_m > 0) begin
                    calm_m  = calm_m - 1;
                    stall_m = 0;
                end else begin
                    stall_m = $urandom_range(0, 7);
                    if ($urandom_range(0, 20) == 0) calm_m = $urandom_range(5, 20);
                end
            end
            if (stall_m > 0) begin
                m_tready <= 1'b0;
                stall_m = stall_m - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("response_frame_checker: mismatch");
            $finish;
        end
    end

    // Stimulus
    initial begin
        row_t        row;
        item_t       it;
        int          goal;
        bit          paused;
        logic [15:0] tmo_plan[6];

        paused      = 1'b0;
        tmo_plan[0] = TIMEOUT_RESET;
        tmo_plan[1] = 16'd1;
        tmo_plan[2] = 16'd0;
        tmo_plan[3] = 16'hFFFF;
        tmo_plan[4] = 16'd3;
        tmo_plan[5] = 16'($urandom_range(1, 12));

        // idle after reset: bytes, ticks and the unused op do nothing
        add_row(mk_row(OP_BYTE,   8'hAA, 8'h00, 8'h00, 8'h00, ROW_NONE, NO_RES));
        add_row(mk_row(OP_TICK,   8'h00, 8'h00, 8'h00, 8'h00, ROW_NONE, NO_RES));
        add_row(mk_row(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, ROW_NONE, NO_RES));
        // bad header, then a byte ignored after the error
        add_row(mk_row(OP_START,  8'h00, 8'h12, 8'h34, 8'h00, ROW_NONE, NO_RES));
        add_row(mk_row(OP_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, ROW_RES,
                       '{KIND_STATUS, 8'h00, ST_BAD_HEADER, 1'b1}));
        add_row(mk_row(OP_BYTE,   8'hFB, 8'h00, 8'h00, 8'h00, ROW_NONE, NO_RES));
        // wrong id, all-ones expectations
        add_row(mk_row(OP_START,  8'h00, 8'hFF, 8'hFF, 8'hFF, ROW_NONE, NO_RES));
        add_row(mk_row(OP_BYTE,   8'hFB, 8'h00, 8'h00, 8'h00, ROW_NONE, NO_RES));
        add_row(mk_row(OP_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, ROW_RES,
                       '{KIND_STATUS, 8'h00, ST_WRONG_ID, 1'b1}));
        // wrong code
        add_row(mk_row(OP_START,  8'h00, 8'h00, 8'h00, 8'h01, ROW_NONE, NO_RES));
        add_row(mk_row(OP_BYTE,   8'hFB, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_BYTE,   8'hFF, 8'h00, 8'h00, 8'h00, ROW_RES,
                       '{KIND_STATUS, 8'h00, ST_WRONG_CODE, 1'b1}));
        // start while a reply is pending re-arms silently
        add_row(mk_row(OP_START,  8'h00, 8'h01, 8'h02, 8'h00, ROW_NONE, NO_RES));
        add_row(mk_row(OP_BYTE,   8'hFB, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_START,  8'h00, 8'hFF, 8'h80, 8'h02, ROW_NONE, NO_RES));
        // full reply with extreme payload bytes and a good checksum
        add_row(mk_row(OP_BYTE,   8'hFB, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_TICK,   8'h00, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_BYTE,   8'hFF, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_BYTE,   8'h80, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, ROW_RES,
                       '{KIND_PAYLOAD, 8'h00, ST_OK, 1'b0}));
        add_row(mk_row(OP_BYTE,   8'hFF, 8'h00, 8'h00, 8'h00, ROW_RES,
                       '{KIND_PAYLOAD, 8'hFF, ST_OK, 1'b0}));
        add_row(mk_row(OP_BYTE,   8'h79, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        // zero payload length, checksum right after the code, and it is wrong
        add_row(mk_row(OP_START,  8'h00, 8'h01, 8'h02, 8'h00, ROW_NONE, NO_RES));
        add_row(mk_row(OP_BYTE,   8'hFB, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_BYTE,   8'h01, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_BYTE,   8'h02, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));
        add_row(mk_row(OP_BYTE,   8'h00, 8'h00, 8'h00, 8'h00, ROW_PRED, NO_RES));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_q[i]) begin
            row              = dir_q[i];
            it.op            = row.op;
            it.rx_byte       = row.rx_byte;
            it.expected_id   = row.id;
            it.expected_code = row.code;
            it.expected_len  = row.len;
            drive_beat(it, row.mode, row.res);
        end

        // random replies, one timeout setting per phase
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                drain();
                write_timeout(tmo_plan[p]);
            end
            goal = n_live + PHASE_BEATS;
            while (n_live < goal) begin
                plan_reply();
                while (plan_q.size() != 0) drive_beat(plan_q.pop_front(), ROW_PRED, NO_RES);
                if (p == 1 && !paused && n_live >= goal - PHASE_BEATS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        $display("%0d beats sent (%0d not ignored) over %0d timeout settings",
                 n_beats, n_live, n_settings + 1);
        $display("%0d payload and %0d status results checked, %0d of them timeouts",
                 n_payload, n_status, n_timeout);
        if (errors == 0) begin
            $display("response_frame_checker: match");
        end else begin
            $display("response_frame_checker: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/rfc_pkg.sv
design/rfc_in_stage.sv
design/rfc_core.sv
design/rfc_out_stage.sv
design/response_frame_checker.sv
verif/response_frame_checker_test.sv
